>>> rtl/dcir_pkg.sv
// Shared types and constants for the daisy-chain instruction relay.
`timescale 1ns / 1ps
`default_nettype none

package dcir_pkg;

    // Configuration register width and reset values
    localparam int CFG_W = 20;
    localparam logic [CFG_W-1:0] MIN_HIGH_RESET = CFG_W'(50);
    localparam logic [CFG_W-1:0] IDLE_GAP_RESET = CFG_W'(5000);

    // Configuration register indexes
    localparam logic REG_MIN_CLOCK_HIGH = 1'b0;
    localparam logic REG_IDLE_GAP       = 1'b1;

    // Item selector codes
    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_STROBE = 2'd1;
    localparam logic [1:0] FUNC_TEST   = 2'd2;
    localparam logic [1:0] FUNC_NOP    = 2'd3;

    // One input item
    typedef struct packed {
        logic [1:0] func;
        logic [3:0] instr_bits;
    } t_item;

    // One result item
    typedef struct packed {
        logic       forwarding;
        logic       own_new;
        logic [3:0] own_bits;
        logic       out_clock;
        logic [3:0] out_bits;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/dcir_in_stage.sv
// Input register that holds one accepted item until the core consumes it.
`timescale 1ns / 1ps
`default_nettype none

module dcir_in_stage
    import dcir_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_item i_item,
    input  wire logic  i_take,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;

    // Room when empty or when the held item moves on this cycle
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload register
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

>>> rtl/dcir_core.sv
// Relay state, configuration registers and the per-item update logic.
`timescale 1ns / 1ps
`default_nettype none

module dcir_core
    import dcir_pkg::*;
#(
    parameter int TIME_BITS = 20
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire logic             i_go,
    input  wire t_item            i_item,
    output t_result               o_res
);

    localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    logic [CFG_W-1:0]     r_min_high;
    logic [CFG_W-1:0]     r_idle_gap;
    logic                 r_fwd, n_fwd;
    logic                 r_clock_high, n_clock_high;
    logic [TIME_BITS-1:0] r_since_send, n_since_send;
    logic [TIME_BITS-1:0] r_since_read, n_since_read;
    logic [3:0]           r_out_bits, n_out_bits;
    logic [3:0]           r_own_bits, n_own_bits;
    logic                 n_own_new;

    logic [TIME_BITS-1:0] inc_send;
    logic [TIME_BITS-1:0] inc_read;
    logic                 high_done;
    logic                 gap_done;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_high <= MIN_HIGH_RESET;
            r_idle_gap <= IDLE_GAP_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_MIN_CLOCK_HIGH) begin
                r_min_high <= i_cfg_data;
            end else begin
                r_idle_gap <= i_cfg_data;
            end
        end
    end

    // Saturating time counters and their timeout compares
    assign inc_send  = (r_since_send == TIME_MAX) ? r_since_send : r_since_send + 1'b1;
    assign inc_read  = (r_since_read == TIME_MAX) ? r_since_read : r_since_read + 1'b1;
    assign high_done = CMP_W'(inc_send) > CMP_W'(r_min_high);
    assign gap_done  = CMP_W'(inc_read) > CMP_W'(r_idle_gap);

    // Next state for the item at the head of the input register
    always_comb begin
        n_fwd        = r_fwd;
        n_clock_high = r_clock_high;
        n_since_send = r_since_send;
        n_since_read = r_since_read;
        n_out_bits   = r_out_bits;
        n_own_bits   = r_own_bits;
        n_own_new    = 1'b0;
        case (i_item.func)
            FUNC_TICK: begin
                n_since_send = inc_send;
                n_since_read = inc_read;
                if (r_fwd) begin
                    if (r_clock_high) begin
                        if (high_done) begin
                            n_clock_high = 1'b0;
                        end
                    end else if (gap_done) begin
                        n_fwd      = 1'b0;
                        n_out_bits = 4'd0;
                    end
                end
            end
            FUNC_STROBE: begin
                if (r_fwd) begin
                    n_out_bits   = i_item.instr_bits;
                    n_clock_high = 1'b1;
                    n_since_send = '0;
                end else begin
                    // first strobe after the idle gap is kept as our own
                    n_own_bits = i_item.instr_bits;
                    n_own_new  = 1'b1;
                    n_fwd      = 1'b1;
                end
                n_since_read = '0;
            end
            FUNC_TEST: begin
                n_fwd        = 1'b1;
                n_out_bits   = i_item.instr_bits;
                n_clock_high = 1'b1;
                n_since_send = '0;
            end
            default: begin
                // no operation: state holds
            end
        endcase
    end

    // State registers advance once per consumed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd        <= 1'b0;
            r_clock_high <= 1'b0;
            r_since_send <= '0;
            r_since_read <= '0;
            r_out_bits   <= 4'd0;
            r_own_bits   <= 4'd0;
        end else if (i_go) begin
            r_fwd        <= n_fwd;
            r_clock_high <= n_clock_high;
            r_since_send <= n_since_send;
            r_since_read <= n_since_read;
            r_out_bits   <= n_out_bits;
            r_own_bits   <= n_own_bits;
        end
    end

    // Result reflects the state after this item
    always_comb begin
        o_res.out_bits   = n_out_bits;
        o_res.out_clock  = n_clock_high;
        o_res.own_bits   = n_own_bits;
        o_res.own_new    = n_own_new;
        o_res.forwarding = n_fwd;
    end

    // Clock line is only raised while forwarding, and leaving drops it first
    a_clock_needs_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clock_high |-> r_fwd)
        else $error("output clock high outside forwarding");

    // Output data is cleared whenever not forwarding
    a_idle_out_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_fwd |-> (r_out_bits == 4'd0))
        else $error("output data not cleared while idle");

    // A new own instruction is only latched from the idle mode
    a_own_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && n_own_new) |-> (!r_fwd && n_fwd))
        else $error("own instruction latched while forwarding");

    // Test send always leaves the clock high and forwarding on
    a_test_drives: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && (i_item.func == FUNC_TEST)) |=> (r_clock_high && r_fwd))
        else $error("test send did not drive the chain");

endmodule

`default_nettype wire

>>> rtl/dcir_out_stage.sv
// Result register that holds one result until the downstream side takes it.
`timescale 1ns / 1ps
`default_nettype none

module dcir_out_stage
    import dcir_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_res,
    input  wire logic    i_ready,
    output logic         o_valid,
    output logic         o_free,
    output t_result      o_res
);

    logic    r_valid;
    t_result r_res;

    // Free when empty or when the held result transfers this cycle
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

>>> rtl/daisy_chain_instruction_relay_top.sv
// Top level of the daisy-chain instruction relay node.
`timescale 1ns / 1ps
`default_nettype none

// Relay node: the first strobe after an idle gap is kept as the node's own
// instruction, later strobes are driven on to the next node with a clock
// pulse whose high time and the idle gap are counted in tick items. Each item
// gives exactly one result. Throughput is one item per clock cycle unless the
// result stream stalls; items pass the input register, the state update and
// the result register. Configuration is taken at any write enable.
module daisy_chain_instruction_relay_top
    import dcir_pkg::*;
#(
    parameter int TIME_BITS = 20
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // configuration write port
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    // input stream
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [7:0]       s_axis_tdata,   // [3:0] instr_bits, [7:4] zero
    input  wire logic [1:0]       s_axis_tuser,   // [1:0] func
    // result stream
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [15:0]           m_axis_tdata    // [3:0] out_bits, [4] out_clock,
                                                  // [8:5] own_bits, [9] own_new,
                                                  // [10] forwarding, [15:11] zero
);

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    out_free;
    logic    go;
    t_result core_res;
    t_result out_res;

    assign in_item.func       = s_axis_tuser;
    assign in_item.instr_bits = s_axis_tdata[3:0];

    // Item moves through the core when the result register has room
    assign go = held_valid && out_free;

    dcir_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .i_take  (go),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    dcir_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_go       (go),
        .i_item     (held_item),
        .o_res      (core_res)
    );

    dcir_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (go),
        .i_res   (core_res),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_free  (out_free),
        .o_res   (out_res)
    );

    // Pack the result fields, highest first
    assign m_axis_tdata = {5'd0, out_res.forwarding, out_res.own_new, out_res.own_bits,
                           out_res.out_clock, out_res.out_bits};

endmodule

`default_nettype wire
